>>> hdl/amo_pkg.sv
// Shared types and constants of the alpha mask outline block.
package amo_pkg;

    // Signed canvas coordinate, wide enough for any window bound
    localparam int COORD_W = 9;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Field and register widths
    localparam int POS_W    = 7;
    localparam int ALPHA_W  = 8;
    localparam int COLOUR_W = 32;
    localparam int RADIUS_W = 4;
    localparam int SIZE_W   = 7;
    localparam int CFG_W    = 32;
    localparam int INDEX_W  = 3;
    localparam int EFF_R_W  = 5;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_RADIUS    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_WIDTH     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_HEIGHT    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COLOUR    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_THRESHOLD = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

>>> hdl/alpha_mask_outline.sv
// Top level of the alpha mask outline block: opaque-bit row store and window scanner.
//
// Loads set or clear one opaque bit in a row memory of MAX_HEIGHT rows by MAX_WIDTH
// bits by a row read and then a row write back; a load outside the image is dropped
// in its accept cycle. A query inside the canvas first takes the beat and builds the
// column masks, then reads the window rows from r above to r below its centre, r being
// the radius in force clamped to MAX_RADIUS, one row after another through the single
// registered read port of the row memory, and last settles the answer once the output
// register is free. A query outside the canvas goes from the beat straight to settling
// its answer. in_stall is high while an item is at work; a finished answer waits in
// the output register, and a following load goes on meanwhile. The row memory has no
// reset: every pixel that a query window reaches must have been loaded first.
module alpha_mask_outline #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write_en,
    input  logic [amo_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [amo_pkg::CFG_W-1:0]      cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [amo_pkg::POS_W-1:0]      pos_x,
    input  logic [amo_pkg::POS_W-1:0]      pos_y,
    input  logic [amo_pkg::ALPHA_W-1:0]    pixel_alpha,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_outline,
    output logic [amo_pkg::COLOUR_W-1:0]   pixel_colour
);
    import amo_pkg::*;

    localparam int ADDR_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [EFF_R_W-1:0] MAX_R = EFF_R_W'(MAX_RADIUS);
    localparam logic [10:0] MAX_H = 11'(MAX_HEIGHT);
    localparam logic [10:0] MAX_W = 11'(MAX_WIDTH);

    // Configuration registers
    logic [RADIUS_W-1:0] radius_reg;
    logic [SIZE_W-1:0]   image_width_reg;
    logic [SIZE_W-1:0]   image_height_reg;
    logic [COLOUR_W-1:0] outline_colour_reg;
    logic [ALPHA_W-1:0]  alpha_threshold_reg;

    // Sequencer and scan registers
    state_t                 state_reg, state_next;
    coord_t                 row_reg, row_next;
    coord_t                 last_reg, last_next;
    coord_t                 sy_reg, sy_next;
    logic [MAX_WIDTH-1:0]   win_mask_reg, win_mask_next;
    logic [MAX_WIDTH-1:0]   ctr_mask_reg, ctr_mask_next;
    logic                   any_reg, any_next;
    logic                   center_reg, center_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   rd_center_reg, rd_center_next;
    logic                   ld_set_reg, ld_set_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic                   is_outline_reg, is_outline_next;
    logic [COLOUR_W-1:0]    colour_reg, colour_next;

    // Row memory
    logic [MAX_WIDTH-1:0]   mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]   rd_data_reg;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [MAX_WIDTH-1:0]   wr_data;

    // Effective sizes and coordinates
    logic [EFF_R_W-1:0]     eff_r;
    logic [SIZE_W-1:0]      eff_w;
    logic [SIZE_W-1:0]      eff_h;
    coord_t                 r_s, w_s, h_s, px_s, py_s, sx, sy;
    logic                   in_accept;
    logic                   in_canvas;
    logic                   row_ok;
    logic                   hit;
    logic                   center_hit;
    logic                   result;
    logic                   out_free;
    logic [15:0]            row_addr_wide;
    logic [15:0]            py_addr_wide;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg          <= RADIUS_W'(1);
            image_width_reg     <= SIZE_W'(64);
            image_height_reg    <= SIZE_W'(64);
            outline_colour_reg  <= '0;
            alpha_threshold_reg <= ALPHA_W'(32);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_RADIUS:    radius_reg          <= cfg_data[RADIUS_W-1:0];
                REG_WIDTH:     image_width_reg     <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:    image_height_reg    <= cfg_data[SIZE_W-1:0];
                REG_COLOUR:    outline_colour_reg  <= cfg_data[COLOUR_W-1:0];
                REG_THRESHOLD: alpha_threshold_reg <= cfg_data[ALPHA_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clamp radius and image size
    always_comb
    begin
        eff_r = ({1'b0, radius_reg} > MAX_R) ? MAX_R : {1'b0, radius_reg};
        eff_w = ({4'b0, image_width_reg} > MAX_W) ? MAX_W[SIZE_W-1:0] : image_width_reg;
        eff_h = ({4'b0, image_height_reg} > MAX_H) ? MAX_H[SIZE_W-1:0] : image_height_reg;
        r_s   = $signed({4'b0, eff_r});
        w_s   = $signed({2'b0, eff_w});
        h_s   = $signed({2'b0, eff_h});
        px_s  = $signed({2'b0, pos_x});
        py_s  = $signed({2'b0, pos_y});
        sx    = px_s - r_s;
        sy    = py_s - r_s;
        in_canvas = (px_s < w_s + r_s + r_s) && (py_s < h_s + r_s + r_s);
    end

    // Evaluate the row read in flight
    assign hit        = rd_valid_reg && (|(rd_data_reg & win_mask_reg));
    assign center_hit = rd_valid_reg && rd_center_reg && (|(rd_data_reg & ctr_mask_reg));
    assign result     = (any_reg || hit) && !(center_reg || center_hit);
    assign row_ok     = (row_reg >= 0) && (row_reg < h_s);
    assign out_free   = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign row_addr_wide = 16'($unsigned(row_reg));
    assign py_addr_wide  = 16'(pos_y);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        last_next       = last_reg;
        sy_next         = sy_reg;
        win_mask_next   = win_mask_reg;
        ctr_mask_next   = ctr_mask_reg;
        any_next        = any_reg;
        center_next     = center_reg;
        rd_valid_next   = 1'b0;
        rd_center_next  = 1'b0;
        ld_set_next     = ld_set_reg;
        wr_addr_next    = wr_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        is_outline_next = is_outline_reg;
        colour_next     = colour_reg;
        rd_en           = 1'b0;
        rd_addr         = row_addr_wide[ADDR_W-1:0];
        wr_en           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        // read the target row, modify it next cycle
                        if (px_s < w_s && py_s < h_s)
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = py_addr_wide[ADDR_W-1:0];
                            wr_addr_next  = py_addr_wide[ADDR_W-1:0];
                            ld_set_next   = (pixel_alpha >= alpha_threshold_reg);
                            for (int c = 0; c < MAX_WIDTH; c++)
                                ctr_mask_next[c] = (coord_t'(c) == px_s);
                            state_next    = ST_LOAD;
                        end
                    end
                    else
                    begin
                        // set up the window scan
                        any_next    = 1'b0;
                        center_next = 1'b0;
                        sy_next     = sy;
                        row_next    = sy - r_s;
                        last_next   = sy + r_s;
                        for (int c = 0; c < MAX_WIDTH; c++)
                        begin
                            win_mask_next[c] = (coord_t'(c) >= sx - r_s) &&
                                               (coord_t'(c) <= sx + r_s) &&
                                               (coord_t'(c) < w_s);
                            ctr_mask_next[c] = (coord_t'(c) == sx) && (coord_t'(c) < w_s);
                        end
                        state_next = in_canvas ? ST_SCAN : ST_FINISH;
                    end
                end
            end
            ST_LOAD:
            begin
                // write the modified row back
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // fold the previous row, issue the next
                any_next       = any_reg || hit;
                center_next    = center_reg || center_hit;
                rd_en          = row_ok;
                rd_valid_next  = row_ok;
                rd_center_next = (row_reg == sy_reg);
                row_next       = row_reg + coord_t'(1);
                if (row_reg == last_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // fold the last row and hold until the output slot is free
                any_next    = any_reg || hit;
                center_next = center_reg || center_hit;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    is_outline_next = result;
                    colour_next     = result ? outline_colour_reg : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wr_data = ld_set_reg ? (rd_data_reg | ctr_mask_reg) : (rd_data_reg & ~ctr_mask_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        last_reg       <= last_next;
        sy_reg         <= sy_next;
        win_mask_reg   <= win_mask_next;
        ctr_mask_reg   <= ctr_mask_next;
        any_reg        <= any_next;
        center_reg     <= center_next;
        rd_center_reg  <= rd_center_next;
        ld_set_reg     <= ld_set_next;
        wr_addr_reg    <= wr_addr_next;
        is_outline_reg <= is_outline_next;
        colour_reg     <= colour_next;
    end

    // Row memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign is_outline   = is_outline_reg;
    assign pixel_colour = colour_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_outline_reg) |-> (colour_reg == '0))
        else $error("colour shown on a pixel that is not outline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (row_reg <= last_reg))
        else $error("scan ran past the window");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("row read tagged valid outside the scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> $past(in_valid && !in_stall && operation == OP_LOAD))
        else $error("row write without a load beat");

endmodule

>>> verif/amo_checker.sv
`timescale 1ns / 1ps
// Checker for the alpha mask outline block: mirrors registers and mask, predicts and compares answers.
module amo_checker
    import amo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  operation,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic [ALPHA_W-1:0]    pixel_alpha,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  is_outline,
    input  logic [COLOUR_W-1:0]   pixel_colour,
    output int                    fail_count,
    output int                    pending,
    output int                    result_count
);

    localparam int MASK_W     = 64;
    localparam int MASK_H     = 64;
    localparam int RADIUS_MAX = 8;

    typedef struct packed {
        logic                outline;
        logic [COLOUR_W-1:0] colour;
    } answer_t;

    // Answers of accepted queries, oldest first
    answer_t answer_queue [$];

    // Register mirror
    logic [RADIUS_W-1:0] radius_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [ALPHA_W-1:0]  threshold_reg;

    // One opaque bit per source pixel
    logic [MASK_W-1:0] opaque_mask [MASK_H];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        result_count = 0;
    end

    function automatic int clamp_to(input int v, input int hi);
        return (v > hi) ? hi : v;
    endfunction

    // Padding and anything beyond the image read as transparent
    function automatic logic opaque_at(input int sx, input int sy, input int w, input int h);
        if (sx < 0 || sy < 0 || sx >= w || sy >= h)
            return 1'b0;
        return opaque_mask[sy][sx];
    endfunction

    function automatic answer_t predict_answer(input int px, input int py);
        int      r;
        int      w;
        int      h;
        int      cx;
        int      cy;
        logic    hit;
        answer_t ans;
        r   = clamp_to(int'(radius_reg), RADIUS_MAX);
        w   = clamp_to(int'(width_reg), MASK_W);
        h   = clamp_to(int'(height_reg), MASK_H);
        hit = 1'b0;
        if (px < w + 2 * r && py < h + 2 * r)
        begin
            cx = px - r;
            cy = py - r;
            if (!opaque_at(cx, cy, w, h))
            begin
                for (int y = cy - r; y <= cy + r; y++)
                    for (int x = cx - r; x <= cx + r; x++)
                        if (opaque_at(x, y, w, h))
                            hit = 1'b1;
            end
        end
        ans.outline = hit;
        ans.colour  = hit ? colour_reg : '0;
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int      w;
        int      h;
        if (!rst_n)
        begin
            radius_reg    = 4'd1;
            width_reg     = 7'd64;
            height_reg    = 7'd64;
            colour_reg    = '0;
            threshold_reg = 8'd32;
            foreach (opaque_mask[i])
                opaque_mask[i] = '0;
            answer_queue.delete();
            pending = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_RADIUS:    radius_reg    = cfg_data[RADIUS_W-1:0];
                    REG_WIDTH:     width_reg     = cfg_data[SIZE_W-1:0];
                    REG_HEIGHT:    height_reg    = cfg_data[SIZE_W-1:0];
                    REG_COLOUR:    colour_reg    = cfg_data[COLOUR_W-1:0];
                    REG_THRESHOLD: threshold_reg = cfg_data[ALPHA_W-1:0];
                    default:       ;
                endcase
            end

            // Compare a result beat with the oldest answer
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (answer_queue.size() == 0)
                    report_mismatch("result beat with no query waiting");
                else
                begin
                    want = answer_queue.pop_front();
                    if (is_outline !== want.outline)
                        report_mismatch($sformatf("is_outline %b, expected %b",
                                                  is_outline, want.outline));
                    if (pixel_colour !== want.colour)
                        report_mismatch($sformatf("pixel_colour %h, expected %h",
                                                  pixel_colour, want.colour));
                end
            end

            // Apply a load or predict a query
            if (in_valid && !in_stall)
            begin
                if (operation == OP_QUERY)
                    answer_queue.push_back(predict_answer(int'(pos_x), int'(pos_y)));
                else
                begin
                    w = clamp_to(int'(width_reg), MASK_W);
                    h = clamp_to(int'(height_reg), MASK_H);
                    if (int'(pos_x) < w && int'(pos_y) < h)
                        opaque_mask[pos_y][pos_x] = (pixel_alpha >= threshold_reg);
                end
            end
            pending = answer_queue.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the alpha mask outline testbench: clock, reset, stimulus and verdict.
module testbench;
    import amo_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;
    localparam int RANDOM_GOAL = 540;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_en;
    logic [INDEX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [ALPHA_W-1:0]  pixel_alpha;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                is_outline;
    logic [COLOUR_W-1:0] pixel_colour;

    int fail_count;
    int pending;
    int result_count;

    int   cycles      = 0;
    int   load_count  = 0;
    int   query_count = 0;
    int   phase_count = 0;
    int   random_done = 0;
    logic burst       = 1'b0;

    // Current register values, for picking coordinates
    int cur_radius = 1;
    int cur_width  = 64;
    int cur_height = 64;
    int cur_thr    = 32;

    // Source pixels that have been loaded at least once
    logic [63:0] loaded [64];

    alpha_mask_outline #(
        .MAX_WIDTH  (64),
        .MAX_HEIGHT (64),
        .MAX_RADIUS (8)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pixel_alpha  (pixel_alpha),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_outline   (is_outline),
        .pixel_colour (pixel_colour)
    );

    amo_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pixel_alpha  (pixel_alpha),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_outline   (is_outline),
        .pixel_colour (pixel_colour),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d answers outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: after each result beat draw a random stall, none in a burst phase
    logic rx_taken = 1'b0;
    int   stall_left = 0;

    always @(posedge clk)
        rx_taken <= out_valid && !out_stall;

    always @(negedge clk)
    begin
        if (rx_taken)
            stall_left = burst ? 0 : $urandom_range(0, 5);
        if (stall_left > 0 && out_valid)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int eff_size(input int v, input int hi);
        return (v > hi) ? hi : v;
    endfunction

    // Send one beat after a random gap; return at the edge that accepts it
    task automatic send_item(input logic op, input int x, input int y, input int a);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        operation   <= op;
        pos_x       <= x[POS_W-1:0];
        pos_y       <= y[POS_W-1:0];
        pixel_alpha <= a[ALPHA_W-1:0];
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (op == OP_QUERY)
            query_count++;
        else
            load_count++;
    endtask

    // Load a pixel and note it as written when it lands inside the image
    task automatic load_pixel(input int x, input int y, input int a);
        send_item(OP_LOAD, x, y, a);
        if (x < eff_size(cur_width, 64) && y < eff_size(cur_height, 64))
            loaded[y][x] = 1'b1;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold the sender until every answer is back
    task automatic wait_answers();
        release_input();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Drain, let the block settle, then write all five registers
    task automatic set_config(input int r, input int w, input int h,
                              input logic [31:0] colour, input int thr);
        wait_answers();
        repeat (SETTLE) @(negedge clk);
        write_reg(REG_RADIUS, r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_COLOUR, colour);
        write_reg(REG_THRESHOLD, thr);
        cur_radius = r;
        cur_width  = w;
        cur_height = h;
        cur_thr    = thr;
        phase_count++;
    endtask

    // Load every image pixel that a query window could reach and has no value yet
    task automatic fill_image();
        int ew;
        int eh;
        ew = eff_size(cur_width, 64);
        eh = eff_size(cur_height, 64);
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
                if (!loaded[y][x])
                    load_pixel(x, y, $urandom_range(0, 255));
    endtask

    // Mostly queries inside the canvas and loads inside the image, some noise
    task automatic run_mixed(input int count);
        int r;
        int ew;
        int eh;
        int cw;
        int ch;
        int pick;
        int a;
        r  = eff_size(cur_radius, 8);
        ew = eff_size(cur_width, 64);
        eh = eff_size(cur_height, 64);
        cw = ew + 2 * r;
        ch = eh + 2 * r;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && cw > 0 && ch > 0)
                send_item(OP_QUERY, $urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                          $urandom_range(0, 255));
            else if (pick < 85 && ew > 0 && eh > 0)
            begin
                // Hit the threshold boundary now and then
                if ($urandom_range(0, 3) == 0)
                    a = cur_thr - 1 + $urandom_range(0, 2);
                else
                    a = $urandom_range(0, 255);
                if (a < 0)
                    a = 0;
                if (a > 255)
                    a = 255;
                load_pixel($urandom_range(0, ew - 1), $urandom_range(0, eh - 1), a);
            end
            else if ($urandom_range(0, 1) == 0)
                load_pixel($urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 255));
            else
                send_item(OP_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            random_done++;
            if ($urandom_range(0, 99) == 0)
                wait_answers();
        end
    endtask

    task automatic run_phase(input int r, input int w, input int h,
                             input logic [31:0] colour, input int thr, input int count);
        set_config(r, w, h, colour, thr);
        burst = ($urandom_range(0, 3) == 0);
        fill_image();
        run_mixed(count);
    endtask

    initial
    begin
        int r;
        int w;
        int h;
        int thr;

        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_LOAD;
        pos_x        = '0;
        pos_y        = '0;
        pixel_alpha  = '0;
        foreach (loaded[i])
            loaded[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 4x3 image, radius 2, threshold 128
        set_config(2, 4, 3, 32'hFF00_80C1, 128);
        load_pixel(0, 0, 255);
        load_pixel(1, 0, 0);
        load_pixel(2, 0, 128);
        load_pixel(3, 0, 127);
        for (int y = 1; y < 3; y++)
            for (int x = 0; x < 4; x++)
                load_pixel(x, y, 0);
        // Loads beyond the image are dropped
        load_pixel(4, 0, 255);
        load_pixel(127, 127, 255);
        // Padding corner next to an opaque pixel
        send_item(OP_QUERY, 0, 0, 0);
        // Opaque pixel itself
        send_item(OP_QUERY, 2, 2, 0);
        // Transparent pixel beside one at the threshold
        send_item(OP_QUERY, 5, 2, 0);
        send_item(OP_QUERY, 4, 4, 0);
        send_item(OP_QUERY, 6, 2, 0);
        // Last canvas pixel, then just outside in each direction
        send_item(OP_QUERY, 7, 6, 255);
        send_item(OP_QUERY, 8, 0, 0);
        send_item(OP_QUERY, 0, 7, 0);
        send_item(OP_QUERY, 127, 127, 255);

        // Corner settings: zero radius, saturated radius, empty image,
        // saturated sizes, threshold extremes, colour extremes
        run_phase(0, 5, 5, 32'hFFFF_FFFF, 32, 50);
        run_phase(15, 6, 4, 32'h1234_5678, 0, 60);
        run_phase(8, 0, 9, 32'hFFFF_FFFF, 255, 40);
        run_phase(1, 127, 1, 32'h0000_0000, 100, 60);
        run_phase(3, 1, 127, 32'hDEAD_BEEF, 255, 60);
        run_phase(1, 1, 1, 32'h8000_0001, 255, 40);
        run_phase(8, 64, 1, 32'h5A5A_A5A5, 0, 60);

        // Random settings, mostly small images
        while (random_done < RANDOM_GOAL)
        begin
            if ($urandom_range(0, 9) == 0)
                r = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
            else
                r = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
            begin
                // Saturated width over one row, or saturated height over one column
                if ($urandom_range(0, 1) == 0)
                begin
                    w = $urandom_range(64, 127);
                    h = 1;
                end
                else
                begin
                    w = 1;
                    h = $urandom_range(64, 127);
                end
            end
            else
            begin
                w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            end
            case ($urandom_range(0, 3))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            run_phase(r, w, h, $urandom, thr, $urandom_range(50, 90));
        end

        // Drain and let the block settle
        wait_answers();
        repeat (SETTLE) @(negedge clk);

        $display("Ran %0d register settings with %0d loads and %0d queries",
                 phase_count, load_count, query_count);
        $display("Checked %0d answer beats in %0d cycles", result_count, cycles);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
